// File: hdl/fddf_pkg.sv
// ============================================================================
// fddf_pkg
// Shared types, constants and helper functions of the four-digit decimal
// display formatter.
// ============================================================================
package fddf_pkg;

   localparam int VALUE_W       = 25;  // input value, two's complement
   localparam int DEC_W         = 2;   // decimals count
   localparam int CODE_W        = 4;   // digit code
   localparam int POINT_W       = 3;   // point position
   localparam int NUM_W         = 14;  // shown magnitude, below 10000
   localparam int POW_W         = 10;  // ten to the power 0..3
   localparam int FRAC_BITS_DEF = 10;

   // range limits and blanking thresholds, in whole units
   localparam int MAX_SHOWN     = 9999;
   localparam int MIN_SHOWN     = 999;
   localparam int POS_LIMIT     = 10000;
   localparam int NEG_LIMIT     = 1000;

   // digit codes
   localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;
   localparam logic [CODE_W-1:0] CODE_MINUS = 4'd11;

   // point positions
   localparam logic [POINT_W-1:0] POINT_NONE = 3'd0;
   localparam logic [POINT_W-1:0] POINT_MAX  = 3'd4;

   // decimals counts
   localparam logic [DEC_W-1:0] DEC_ZERO  = 2'd0;
   localparam logic [DEC_W-1:0] DEC_ONE   = 2'd1;
   localparam logic [DEC_W-1:0] DEC_TWO   = 2'd2;
   localparam logic [DEC_W-1:0] DEC_THREE = 2'd3;

   // scaled and range-checked value, between the two stages
   typedef struct packed {
      logic              ok;       // in range, fits the display
      logic              neg;
      logic [DEC_W-1:0]  dec;
      logic              lt1000;   // |value| below 1000
      logic              lt100;
      logic              lt10;
      logic [NUM_W-1:0]  num;      // truncated scaled magnitude
   } fddf_mid_type;

   // one display result
   typedef struct packed {
      logic [CODE_W-1:0]  d4;
      logic [CODE_W-1:0]  d3;
      logic [CODE_W-1:0]  d2;
      logic [CODE_W-1:0]  d1;
      logic [POINT_W-1:0] point;
      logic               ok;
   } fddf_disp_type;

   function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] dec);
      logic [POW_W-1:0] p;
      case (dec)
         DEC_ZERO: p = 10'd1;
         DEC_ONE:  p = 10'd10;
         DEC_TWO:  p = 10'd100;
         default:  p = 10'd1000;
      endcase
      return p;
   endfunction

   // reciprocal multiplies, exact for x below 10000
   function automatic logic [9:0] div10(input logic [NUM_W-1:0] x);
      logic [29:0] p;
      p = 30'(x) * 30'd52429;
      return p[28:19];
   endfunction

   function automatic logic [6:0] div100(input logic [NUM_W-1:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'd5243;
      return p[25:19];
   endfunction

   function automatic logic [3:0] div1000(input logic [NUM_W-1:0] x);
      logic [27:0] p;
      p = 28'(x) * 28'd8389;
      return p[26:23];
   endfunction

endpackage

// File: hdl/fddf_scale.sv
// ============================================================================
// fddf_scale
// Range check, magnitude, scaling by ten to the decimals and truncation.
// ============================================================================
module fddf_scale #(
   parameter int FRAC_BITS = fddf_pkg::FRAC_BITS_DEF
) (
   input  logic signed [fddf_pkg::VALUE_W-1:0] value_fixed,
   input  logic [fddf_pkg::DEC_W-1:0]          decimals,
   output fddf_pkg::fddf_mid_type              mid
);

   localparam int VW = fddf_pkg::VALUE_W;
   localparam int CW = VW + FRAC_BITS + 2;        // compare width
   localparam int PW = VW + fddf_pkg::POW_W;      // product width

   localparam logic signed [CW-1:0] HI_LIM =
      CW'(fddf_pkg::MAX_SHOWN) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] LO_LIM =
      -(CW'(fddf_pkg::MIN_SHOWN) <<< FRAC_BITS);
   localparam logic [CW-1:0] TH1000 = CW'(1000) << FRAC_BITS;
   localparam logic [CW-1:0] TH100  = CW'(100) << FRAC_BITS;
   localparam logic [CW-1:0] TH10   = CW'(10) << FRAC_BITS;

   logic signed [CW-1:0] v_ext;
   logic                 neg;
   logic [VW-1:0]        vbits;
   logic [VW-1:0]        mag;
   logic [CW-1:0]        mag_ext;
   logic [PW-1:0]        prod;
   logic [PW-1:0]        num_full;
   logic                 in_range;
   logic                 too_long;

   always_comb begin
      v_ext    = CW'(value_fixed);
      vbits    = value_fixed;
      neg      = value_fixed[VW-1];
      mag      = neg ? (~vbits + 1'b1) : vbits;
      mag_ext  = CW'(mag);
      in_range = (v_ext >= LO_LIM) && (v_ext <= HI_LIM);
      prod     = PW'(mag) * PW'(fddf_pkg::pow10(decimals));
      num_full = prod >> FRAC_BITS;
      too_long = neg ? (num_full >= PW'(fddf_pkg::NEG_LIMIT))
                     : (num_full >= PW'(fddf_pkg::POS_LIMIT));

      mid.ok     = in_range && !too_long;
      mid.neg    = neg;
      mid.dec    = decimals;
      mid.lt1000 = mag_ext < TH1000;
      mid.lt100  = mag_ext < TH100;
      mid.lt10   = mag_ext < TH10;
      mid.num    = num_full[fddf_pkg::NUM_W-1:0];
   end

endmodule

// File: hdl/fddf_format.sv
// ============================================================================
// fddf_format
// Digit split, leading and trailing blanking, sign and point position.
// ============================================================================
module fddf_format (
   input  fddf_pkg::fddf_mid_type  mid,
   output fddf_pkg::fddf_disp_type disp
);

   logic [9:0]                      q1;
   logic [6:0]                      q2;
   logic [3:0]                      q3;
   logic [fddf_pkg::NUM_W-1:0]      r1;
   logic [9:0]                      r2;
   logic [6:0]                      r3;
   logic [fddf_pkg::CODE_W-1:0]     d4, d3, d2, d1;
   logic [fddf_pkg::POINT_W-1:0]    pt;

   always_comb begin
      q1 = fddf_pkg::div10(mid.num);
      q2 = fddf_pkg::div100(mid.num);
      q3 = fddf_pkg::div1000(mid.num);
      r1 = mid.num - 14'(q1) * 14'd10;
      r2 = q1 - 10'(q2) * 10'd10;
      r3 = q2 - 7'(q3) * 7'd10;

      d1 = r1[3:0];
      d2 = r2[3:0];
      d3 = r3[3:0];
      d4 = mid.neg ? fddf_pkg::CODE_MINUS : q3;

      case (mid.dec)
         fddf_pkg::DEC_ZERO: begin
            if (!mid.neg && mid.lt1000) d4 = fddf_pkg::CODE_BLANK;
            if (mid.lt100)              d3 = fddf_pkg::CODE_BLANK;
            if (mid.lt10)               d2 = fddf_pkg::CODE_BLANK;
         end
         fddf_pkg::DEC_ONE: begin
            if (!mid.neg && mid.lt100)  d4 = fddf_pkg::CODE_BLANK;
            if (mid.lt10)               d3 = fddf_pkg::CODE_BLANK;
         end
         fddf_pkg::DEC_TWO: begin
            if (!mid.neg && mid.lt10)   d4 = fddf_pkg::CODE_BLANK;
            if (r1[3:0] == 4'd0)        d1 = fddf_pkg::CODE_BLANK;
         end
         default: begin
            // trailing zeros go dark
            if (r2[3:0] == 4'd0 && r1[3:0] == 4'd0) d2 = fddf_pkg::CODE_BLANK;
            if (r1[3:0] == 4'd0)                    d1 = fddf_pkg::CODE_BLANK;
         end
      endcase

      pt = (mid.dec == fddf_pkg::DEC_ZERO) ? fddf_pkg::POINT_NONE
                                           : fddf_pkg::POINT_W'(mid.dec) + 3'd1;

      if (mid.ok) begin
         disp.d4    = d4;
         disp.d3    = d3;
         disp.d2    = d2;
         disp.d1    = d1;
         disp.point = pt;
         disp.ok    = 1'b1;
      end else begin
         disp.d4    = fddf_pkg::CODE_BLANK;
         disp.d3    = fddf_pkg::CODE_BLANK;
         disp.d2    = fddf_pkg::CODE_BLANK;
         disp.d1    = fddf_pkg::CODE_BLANK;
         disp.point = fddf_pkg::POINT_NONE;
         disp.ok    = 1'b0;
      end
   end

endmodule

// File: hdl/four_digit_decimal_formatter_unit.sv
// ============================================================================
// four_digit_decimal_formatter_unit
// Formats a signed fixed-point value into four display digit codes, a point
// position and an accept flag.
// ============================================================================
//
//   channel   dir   handshake              payload
//   req_      in    req_valid/req_ready    value_fixed, decimals
//   rsp_      out   rsp_valid/rsp_ready    digit4..1_code, point_digit, accepted
//
// One beat per cycle sustained while rsp_ready stays high; a request beat is offered
// as a result once it has moved through the input, scale and result registers.
// The scale stage holds the one real multiplier (magnitude by 10^decimals);
// the digit split uses constant reciprocal multiplies in the next stage.
// Reset clears the stage valids only. A stall at rsp_ready fills the empty
// stages, then drops req_ready; no beat is lost or repeated.
//
module four_digit_decimal_formatter_unit #(
   parameter int FRAC_BITS = fddf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fddf_pkg::VALUE_W-1:0] req_value_fixed,
   input  logic [fddf_pkg::DEC_W-1:0]          req_decimals,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fddf_pkg::CODE_W-1:0]         rsp_digit4_code,
   output logic [fddf_pkg::CODE_W-1:0]         rsp_digit3_code,
   output logic [fddf_pkg::CODE_W-1:0]         rsp_digit2_code,
   output logic [fddf_pkg::CODE_W-1:0]         rsp_digit1_code,
   output logic [fddf_pkg::POINT_W-1:0]        rsp_point_digit,
   output logic                                rsp_accepted
);

   logic                                in_vld_ff;
   logic signed [fddf_pkg::VALUE_W-1:0] in_value_ff;
   logic [fddf_pkg::DEC_W-1:0]          in_dec_ff;
   logic                                mid_vld_ff;
   fddf_pkg::fddf_mid_type              mid_ff;
   fddf_pkg::fddf_mid_type              mid_in;
   logic                                out_vld_ff;
   fddf_pkg::fddf_disp_type             out_ff;
   fddf_pkg::fddf_disp_type             out_in;

   logic out_rdy, mid_rdy;

   // a stage takes a new beat when it is empty or its contents move on
   assign out_rdy   = !out_vld_ff || rsp_ready;
   assign mid_rdy   = !mid_vld_ff || out_rdy;
   assign req_ready = !in_vld_ff || mid_rdy;

   fddf_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .value_fixed (in_value_ff),
      .decimals    (in_dec_ff),
      .mid         (mid_in)
   );

   fddf_format u_format (
      .mid  (mid_ff),
      .disp (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) in_vld_ff  <= req_valid;
         if (mid_rdy)   mid_vld_ff <= in_vld_ff;
         if (out_rdy)   out_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_value_ff <= req_value_fixed;
         in_dec_ff   <= req_decimals;
      end
      if (mid_rdy && in_vld_ff) begin
         mid_ff <= mid_in;
      end
      if (out_rdy && mid_vld_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_digit4_code = out_ff.d4;
   assign rsp_digit3_code = out_ff.d3;
   assign rsp_digit2_code = out_ff.d2;
   assign rsp_digit1_code = out_ff.d1;
   assign rsp_point_digit = out_ff.point;
   assign rsp_accepted    = out_ff.ok;

endmodule

// File: hdl/fddf_check.sv
// ============================================================================
// fddf_check
// Port-level checks on the formatter's result channel.
// ============================================================================
module fddf_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fddf_pkg::CODE_W-1:0]         rsp_digit4_code,
   input logic [fddf_pkg::CODE_W-1:0]         rsp_digit3_code,
   input logic [fddf_pkg::CODE_W-1:0]         rsp_digit2_code,
   input logic [fddf_pkg::CODE_W-1:0]         rsp_digit1_code,
   input logic [fddf_pkg::POINT_W-1:0]        rsp_point_digit,
   input logic                                rsp_accepted
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a rejected value shows a dark display
   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |->
         rsp_digit4_code == fddf_pkg::CODE_BLANK &&
         rsp_digit3_code == fddf_pkg::CODE_BLANK &&
         rsp_digit2_code == fddf_pkg::CODE_BLANK &&
         rsp_digit1_code == fddf_pkg::CODE_BLANK &&
         rsp_point_digit == fddf_pkg::POINT_NONE)
      else $error("rejected beat with lit segments");

   // minus only on the leftmost digit, codes within range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_digit4_code <= fddf_pkg::CODE_MINUS &&
         rsp_digit3_code <= fddf_pkg::CODE_BLANK &&
         rsp_digit2_code <= fddf_pkg::CODE_BLANK &&
         rsp_digit1_code <= fddf_pkg::CODE_BLANK)
      else $error("digit code out of range");

   // point sits on digit 2..4 or nowhere
   a_point_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_point_digit != 3'd1 &&
                    rsp_point_digit <= fddf_pkg::POINT_MAX)
      else $error("bad point position");

endmodule

bind four_digit_decimal_formatter_unit fddf_check u_fddf_check (.*);
